@@ src/ldr_pkg.sv @@
// ----------------------------------------------------------------------------
// ldr_pkg
// Shared types and constants of the limb-darkened disk raster unit.
// ----------------------------------------------------------------------------
package ldr_pkg;

    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;
    localparam int INT_W       = 20;
    localparam int MAX_DIM_DEF = 4096;

    localparam int DIFF_W   = 18;
    localparam int S_W      = 33;
    localparam int P_W      = 33;
    localparam int PFULL_W  = 57;
    localparam int MUL_W    = 34;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ROOT_W   = 17;
    localparam int ROOT_STEPS = 17;
    localparam int ROOT_CNT_W = 5;
    localparam int T_W      = 21;
    localparam int SUM_W    = 23;

    localparam int ONE_Q16     = 65536;
    localparam int INT_MIN_Q16 = -196608;
    localparam int INT_MAX_Q16 = 327680;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_FRAME_ROWS  = 3'd0,
        REG_FRAME_COLS  = 3'd1,
        REG_CENTER_ROW  = 3'd2,
        REG_CENTER_COL  = 3'd3,
        REG_INV_RAD_SQ  = 3'd4,
        REG_LIMB_LIN    = 3'd5,
        REG_LIMB_QUAD   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]  frame_rows;
        logic [DIM_W-1:0]  frame_cols;
        logic [15:0]       center_row;
        logic [15:0]       center_col;
        logic [31:0]       inv_radius_sq;
        logic signed [15:0] limb_linear;
        logic signed [15:0] limb_quadratic;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQR,
        S_SQC,
        S_SUM,
        S_SCALE,
        S_PCAP,
        S_T2M,
        S_T2C,
        S_ROOT,
        S_T1M,
        S_T1C,
        S_FIN
    } t_state;

endpackage

@@ src/ldr_if.sv @@
// ----------------------------------------------------------------------------
// ldr_in_if / ldr_out_if
// Valid/ready channels for pixel requests and produced pixels.
// ----------------------------------------------------------------------------
interface ldr_in_if;
    logic valid;
    logic ready;
    logic restart_frame;

    modport source (output valid, output restart_frame, input ready);
    modport sink   (input valid, input restart_frame, output ready);
endinterface

interface ldr_out_if import ldr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [COORD_W-1:0]       pixel_row;
    logic [COORD_W-1:0]       pixel_col;
    logic signed [INT_W-1:0]  intensity;
    logic                     last_of_frame;

    modport source (output valid, output pixel_row, output pixel_col,
                    output intensity, output last_of_frame, input ready);
    modport sink   (input valid, input pixel_row, input pixel_col,
                    input intensity, input last_of_frame, output ready);
endinterface

@@ src/ldr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ldr_cfg_regs
// APB register bank holding frame size, disk geometry and limb coefficients.
// ----------------------------------------------------------------------------
module ldr_cfg_regs import ldr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_rows     <= DIM_W'(64);
            r_cfg.frame_cols     <= DIM_W'(64);
            r_cfg.center_row     <= 16'd512;
            r_cfg.center_col     <= 16'd512;
            r_cfg.inv_radius_sq  <= 32'd16777216;
            r_cfg.limb_linear    <= 16'sd0;
            r_cfg.limb_quadratic <= 16'sd0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FRAME_ROWS: r_cfg.frame_rows     <= pwdata[DIM_W-1:0];
                REG_FRAME_COLS: r_cfg.frame_cols     <= pwdata[DIM_W-1:0];
                REG_CENTER_ROW: r_cfg.center_row     <= pwdata[15:0];
                REG_CENTER_COL: r_cfg.center_col     <= pwdata[15:0];
                REG_INV_RAD_SQ: r_cfg.inv_radius_sq  <= pwdata;
                REG_LIMB_LIN:   r_cfg.limb_linear    <= $signed(pwdata[15:0]);
                REG_LIMB_QUAD:  r_cfg.limb_quadratic <= $signed(pwdata[15:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_ROWS: prdata = APB_DATA_W'(r_cfg.frame_rows);
            REG_FRAME_COLS: prdata = APB_DATA_W'(r_cfg.frame_cols);
            REG_CENTER_ROW: prdata = APB_DATA_W'(r_cfg.center_row);
            REG_CENTER_COL: prdata = APB_DATA_W'(r_cfg.center_col);
            REG_INV_RAD_SQ: prdata = r_cfg.inv_radius_sq;
            REG_LIMB_LIN:   prdata = APB_DATA_W'($unsigned(r_cfg.limb_linear));
            REG_LIMB_QUAD:  prdata = APB_DATA_W'($unsigned(r_cfg.limb_quadratic));
            default:        prdata = '0;
        endcase
    end

endmodule

@@ src/ldr_mul.sv @@
// ----------------------------------------------------------------------------
// ldr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ldr_mul import ldr_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    assign n_prod = PROD_W'(i_a) * PROD_W'(i_b);
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

endmodule

@@ src/ldr_isqrt.sv @@
// ----------------------------------------------------------------------------
// ldr_isqrt
// Bit-serial integer square root, two radicand bits per cycle, fixed length.
// ----------------------------------------------------------------------------
module ldr_isqrt import ldr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [P_W-1:0]    i_radicand,
    output logic [ROOT_W-1:0] o_root,
    output t_root_stat        o_stat
);

    localparam int ACC_W = P_W + 1;

    logic [ACC_W-1:0]      r_v;
    logic [ACC_W-1:0]      r_res;
    logic [ACC_W-1:0]      r_bit;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [ACC_W-1:0]      trial;
    logic                  take;

    assign trial  = r_res + r_bit;
    assign take   = (r_v >= trial);
    assign o_root = r_res[ROOT_W-1:0];
    assign o_stat = '{busy: r_busy, done: r_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= ROOT_CNT_W'(ROOT_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= ACC_W'(i_radicand);
            r_res <= '0;
            r_bit <= ACC_W'(1) << (2 * (ROOT_STEPS - 1));
        end else if (r_busy) begin
            if (take) begin
                r_v   <= r_v - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

endmodule

@@ src/limb_darkened_disk_raster_unit.sv @@
// Sequencing: an accepted pixel request makes five passes through the shared
// multiplier and runs the 17-step square root; a pixel outside the disk goes
// straight to the output after the disk test. One request is in flight at a time.
// Reset: synchronous active-low; scan counters to row 0 column 0, registers
// to their defaults.
// ----------------------------------------------------------------------------
// limb_darkened_disk_raster_unit
// Row-major raster of a quadratically limb-darkened stellar disk, one pixel
// per transaction, driven by a sequencer around a shared multiplier.
// ----------------------------------------------------------------------------
module limb_darkened_disk_raster_unit import ldr_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ldr_in_if.sink                i_pix,
    ldr_out_if.source             o_pix,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [DIM_W-1:0]         DIM_MAX  = DIM_W'(MAX_DIM);
    localparam logic [PFULL_W-1:0]       P_ONE    = PFULL_W'(1) << 32;
    localparam logic signed [PROD_W-1:0] T1_HALF  = PROD_W'(1) << 13;
    localparam logic signed [PROD_W-1:0] T2_HALF  = PROD_W'(1) << 29;
    localparam logic signed [SUM_W-1:0]  SUM_ONE  = SUM_W'(ONE_Q16);
    localparam logic signed [SUM_W-1:0]  SUM_LO   = SUM_W'(INT_MIN_Q16);
    localparam logic signed [SUM_W-1:0]  SUM_HI   = SUM_W'(INT_MAX_Q16);

    t_cfg       cfg;
    t_state     r_state;
    t_state     n_state;
    t_root_stat root_stat;

    logic [COORD_W-1:0] r_row_cnt;
    logic [COORD_W-1:0] r_col_cnt;
    logic [COORD_W-1:0] r_cur_row;
    logic [COORD_W-1:0] r_cur_col;
    logic               r_cur_last;
    logic [S_W-1:0]     r_s;
    logic [P_W-1:0]     r_p;
    logic               r_outside;
    logic signed [T_W-1:0] r_t1;
    logic signed [T_W-1:0] r_t2;

    logic                    r_out_valid;
    logic [COORD_W-1:0]      r_out_row;
    logic [COORD_W-1:0]      r_out_col;
    logic signed [INT_W-1:0] r_out_int;
    logic                    r_out_last;

    logic [DIM_W-1:0]   eff_rows;
    logic [DIM_W-1:0]   eff_cols;
    logic               in_acc;
    logic [COORD_W-1:0] acc_row;
    logic [COORD_W-1:0] acc_col;
    logic               col_wrap;
    logic               row_wrap;

    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] dc;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic [PFULL_W-1:0]       p_full;
    logic signed [PROD_W-1:0] t1_sum;
    logic signed [PROD_W-1:0] t2_sum;
    logic [ROOT_W-1:0]        root;
    logic [ROOT_W:0]          one_minus_q;
    logic [P_W-1:0]           radicand;
    logic signed [SUM_W-1:0]  int_sum;
    logic signed [INT_W-1:0]  int_sat;

    logic in_ready;
    logic out_load;
    logic root_start;

    ldr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ldr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    ldr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (radicand),
        .o_root     (root),
        .o_stat     (root_stat)
    );

    assign eff_rows = (cfg.frame_rows == '0) ? DIM_W'(1) :
                      (cfg.frame_rows > DIM_MAX) ? DIM_MAX : cfg.frame_rows;
    assign eff_cols = (cfg.frame_cols == '0) ? DIM_W'(1) :
                      (cfg.frame_cols > DIM_MAX) ? DIM_MAX : cfg.frame_cols;

    assign in_acc   = i_pix.valid && in_ready;
    assign acc_row  = i_pix.restart_frame ? '0 : r_row_cnt;
    assign acc_col  = i_pix.restart_frame ? '0 : r_col_cnt;
    assign col_wrap = (DIM_W'(acc_col) + DIM_W'(1)) >= eff_cols;
    assign row_wrap = (DIM_W'(acc_row) + DIM_W'(1)) >= eff_rows;

    assign dr = $signed({2'b00, r_cur_row, 4'b0000}) - $signed({2'b00, cfg.center_row});
    assign dc = $signed({2'b00, r_cur_col, 4'b0000}) - $signed({2'b00, cfg.center_col});

    assign p_full      = mul_prod[PFULL_W+7:8];
    assign radicand    = P_W'(P_ONE) - r_p;
    assign one_minus_q = (ROOT_W + 1)'(ONE_Q16) - (ROOT_W + 1)'(root);
    assign t1_sum      = mul_prod + T1_HALF;
    assign t2_sum      = mul_prod + T2_HALF;

    assign int_sum = SUM_ONE - SUM_W'(r_t1) - SUM_W'(r_t2);
    assign int_sat = (int_sum < SUM_LO) ? INT_W'(SUM_LO) :
                     (int_sum > SUM_HI) ? INT_W'(SUM_HI) : INT_W'(int_sum);

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) begin
                n_state = S_SQR;
            end
            S_SQR:   n_state = S_SQC;
            S_SQC:   n_state = S_SUM;
            S_SUM:   n_state = S_SCALE;
            S_SCALE: n_state = S_PCAP;
            S_PCAP:  n_state = (p_full > P_ONE) ? S_FIN : S_T2M;
            S_T2M:   n_state = S_T2C;
            S_T2C:   n_state = S_ROOT;
            S_ROOT:  if (!root_stat.busy) begin
                n_state = S_T1M;
            end
            S_T1M:   n_state = S_T1C;
            S_T1C:   n_state = S_FIN;
            S_FIN:   if (out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: unit controls and multiplier operands
    always_comb begin
        in_ready   = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_SQR: begin
                mul_a = MUL_W'(dr);
                mul_b = MUL_W'(dr);
            end
            S_SQC: begin
                mul_a = MUL_W'(dc);
                mul_b = MUL_W'(dc);
            end
            S_SCALE: begin
                mul_a = $signed({1'b0, r_s});
                mul_b = $signed({2'b00, cfg.inv_radius_sq});
            end
            S_T2M: begin
                root_start = 1'b1;
                mul_a      = MUL_W'(cfg.limb_quadratic);
                mul_b      = $signed({1'b0, r_p});
            end
            S_T1M: begin
                mul_a = MUL_W'(cfg.limb_linear);
                mul_b = $signed(MUL_W'(one_minus_q));
            end
            S_FIN: begin
                out_load = !r_out_valid || o_pix.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_cnt   <= '0;
            r_col_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                if (col_wrap) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= row_wrap ? '0 : acc_row + 1'b1;
                end else begin
                    r_col_cnt <= acc_col + 1'b1;
                    r_row_cnt <= acc_row;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur_row  <= acc_row;
            r_cur_col  <= acc_col;
            r_cur_last <= col_wrap && row_wrap;
        end
        unique case (r_state)
            S_SQC:   r_s <= mul_prod[S_W-1:0];
            S_SUM:   r_s <= r_s + mul_prod[S_W-1:0];
            S_PCAP: begin
                r_p       <= p_full[P_W-1:0];
                r_outside <= p_full > P_ONE;
            end
            S_T2C:   r_t2 <= T_W'(t2_sum >>> 30);
            S_T1C:   r_t1 <= T_W'(t1_sum >>> 14);
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_row  <= r_cur_row;
            r_out_col  <= r_cur_col;
            r_out_int  <= r_outside ? '0 : int_sat;
            r_out_last <= r_cur_last;
        end
    end

    assign i_pix.ready         = in_ready;
    assign o_pix.valid         = r_out_valid;
    assign o_pix.pixel_row     = r_out_row;
    assign o_pix.pixel_col     = r_out_col;
    assign o_pix.intensity     = r_out_int;
    assign o_pix.last_of_frame = r_out_last;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SQR))
        else $error("accepted transaction did not start the sequencer");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && col_wrap && row_wrap) |=> (r_row_cnt == '0 && r_col_cnt == '0))
        else $error("scan did not wrap after the last pixel of the frame");

    a_root_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T1M) |-> !root_stat.busy)
        else $error("root consumed while square root still busy");

    a_root_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T2C) |-> root_stat.busy)
        else $error("square root not running after start");
`endif

endmodule
